>>> rtl/esp_pkg.sv
// ----------------------------------------------------------------------------
// esp_pkg
// Types and constants shared by the escape sequence parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package esp_pkg;

  typedef enum logic [2:0] {
    KIND_CHAR = 3'd0,
    KIND_C0   = 3'd1,
    KIND_C1   = 3'd2,
    KIND_ICF  = 3'd3,
    KIND_CSI  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    CODE_NONE = 3'd0,
    CODE_BYTE = 3'd1,
    CODE_C1   = 3'd2,
    CODE_ESC  = 3'd3,
    CODE_PEND = 3'd4
  } code_sel_e;

  localparam logic [7:0] ESC_BYTE    = 8'h1b;
  localparam logic [7:0] CSI8_BYTE   = 8'h9b;
  localparam logic [7:0] LBR_BYTE    = 8'h5b;
  localparam logic [7:0] SEMI_BYTE   = 8'h3b;
  localparam logic [7:0] C0_HI       = 8'h1f;
  localparam logic [7:0] C1_LO       = 8'h80;
  localparam logic [7:0] C1_HI       = 8'h9f;
  localparam logic [7:0] C1_OFFSET   = 8'h40;
  localparam logic [7:0] FE_LO       = 8'h40;
  localparam logic [7:0] FE_HI       = 8'h5f;
  localparam logic [7:0] ICF_LO      = 8'h60;
  localparam logic [7:0] ICF_HI      = 8'h7f;
  localparam logic [7:0] PAR_LO      = 8'h30;
  localparam logic [7:0] DIGIT_HI    = 8'h39;
  localparam logic [7:0] PAR_HI      = 8'h3f;
  localparam logic [7:0] INT_LO      = 8'h20;
  localparam logic [7:0] INT_HI      = 8'h2f;
  localparam logic [7:0] FINAL_LO    = 8'h40;
  localparam logic [7:0] FINAL_HI    = 8'h7e;

  typedef struct packed {
    logic chunk;
    logic is_esc;
    logic is_csi8;
    logic is_c0;
    logic is_c1;
    logic is_lbr;
    logic is_fe;
    logic is_icf;
    logic is_par;
    logic is_int;
    logic is_fin;
    logic run_last;
  } esp_sts_t;

  typedef struct packed {
    logic      csi_clear;
    logic      par_byte;
    logic      inter;
    logic      fin;
    logic      pend_save;
    logic      idx_inc;
    logic      out_load;
    kind_e     out_kind;
    code_sel_e out_code;
    logic      out_last;
  } esp_cmd_t;

endpackage

`default_nettype wire

>>> rtl/esp_if.sv
// ----------------------------------------------------------------------------
// esp_if
// Input and result channels of the escape sequence parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface esp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_end;

  modport source (output valid, output data_byte, output chunk_end, input ready);
  modport sink (input valid, input data_byte, input chunk_end, output ready);
endinterface

interface esp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  code_byte;
  logic [13:0] function_word;
  logic [3:0]  param_total;
  logic [2:0]  param_index;
  logic [15:0] param_value;
  logic        last;

  modport source (
    output valid, output kind, output code_byte, output function_word,
    output param_total, output param_index, output param_value, output last,
    input ready
  );
  modport sink (
    input valid, input kind, input code_byte, input function_word,
    input param_total, input param_index, input param_value, input last,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/esp_ram.sv
// ----------------------------------------------------------------------------
// esp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module esp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/esp_datapath.sv
// ----------------------------------------------------------------------------
// esp_datapath
// Byte classification, CSI parameter and function registers, parameter
// store and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module esp_datapath import esp_pkg::*; #(
  parameter int MAX_PARAMS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        chunk_end_i,
  input  wire esp_cmd_t    cmd_i,
  output esp_sts_t         sts_o,
  output logic [2:0]       kind_o,
  output logic [7:0]       code_byte_o,
  output logic [13:0]      function_word_o,
  output logic [3:0]       param_total_o,
  output logic [2:0]       param_index_o,
  output logic [15:0]      param_value_o,
  output logic             last_o
);

  localparam int CW = $clog2(MAX_PARAMS + 2);
  localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PARAMS);

  logic [CW-1:0] cnt_q, cnt_d, cnt_eff;
  logic [13:0]   func_q, func_d;
  logic [15:0]   cur_q, cur_d, cur_eff;
  logic [IW-1:0] idx_q, idx_d;
  logic [7:0]    pend_q;
  logic          cnt_open;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [15:0]   ram_rdata;
  logic [15:0]   mul10;
  logic [7:0]    code_sel;

  assign sts_o.chunk    = chunk_end_i;
  assign sts_o.is_esc   = (data_byte_i == ESC_BYTE);
  assign sts_o.is_csi8  = (data_byte_i == CSI8_BYTE);
  assign sts_o.is_c0    = (data_byte_i <= C0_HI);
  assign sts_o.is_c1    = data_byte_i inside {[C1_LO:C1_HI]};
  assign sts_o.is_lbr   = (data_byte_i == LBR_BYTE);
  assign sts_o.is_fe    = data_byte_i inside {[FE_LO:FE_HI]};
  assign sts_o.is_icf   = data_byte_i inside {[ICF_LO:ICF_HI]};
  assign sts_o.is_par   = data_byte_i inside {[PAR_LO:PAR_HI]};
  assign sts_o.is_int   = data_byte_i inside {[INT_LO:INT_HI]};
  assign sts_o.is_fin   = data_byte_i inside {[FINAL_LO:FINAL_HI]};
  assign sts_o.run_last = (cnt_q == '0) || ((CW'(idx_q) + CW'(1)) == cnt_q);

  // A parameter byte with no parameter open opens parameter zero first.
  assign cnt_eff  = (cnt_q == '0) ? CW'(1) : cnt_q;
  assign cur_eff  = (cnt_q == '0) ? 16'd0 : cur_q;
  assign cnt_open = (cnt_eff <= CNT_MAX);
  assign mul10    = 16'({cur_eff, 3'b000} + {2'b00, cur_eff, 1'b0});

  assign ram_waddr = IW'(cnt_eff - CW'(1));
  assign ram_we    = cnt_open && (cmd_i.fin ? (cnt_q != '0)
                                            : (cmd_i.par_byte && data_byte_i == SEMI_BYTE));

  always_comb begin
    cnt_d  = cnt_q;
    func_d = func_q;
    cur_d  = cur_q;
    idx_d  = idx_q;
    if (cmd_i.csi_clear) begin
      cnt_d  = '0;
      func_d = '0;
      cur_d  = '0;
    end else if (cmd_i.par_byte) begin
      cnt_d = cnt_eff;
      cur_d = cur_eff;
      if (data_byte_i <= DIGIT_HI) begin
        if (cnt_open) begin
          cur_d = 16'(mul10 + 16'(data_byte_i[3:0]));
        end
      end else if (data_byte_i == SEMI_BYTE) begin
        cur_d = '0;
        if (cnt_open) begin
          cnt_d = cnt_eff + CW'(1);
        end
      end
    end else if (cmd_i.inter) begin
      func_d = {data_byte_i[5:0], 8'h00};
    end else if (cmd_i.fin) begin
      func_d = 14'(func_q + 14'(data_byte_i));
      if (cnt_q > CNT_MAX) begin
        cnt_d = CNT_MAX;
      end
      idx_d = '0;
    end
    if (cmd_i.idx_inc) begin
      idx_d = idx_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      func_q <= '0;
      idx_q  <= '0;
    end else begin
      cnt_q  <= cnt_d;
      func_q <= func_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (cmd_i.pend_save) begin
      pend_q <= data_byte_i;
    end
  end

  esp_ram #(
    .WIDTH (16),
    .DEPTH (MAX_PARAMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cur_eff),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    case (cmd_i.out_code)
      CODE_BYTE: code_sel = data_byte_i;
      CODE_C1:   code_sel = data_byte_i - C1_OFFSET;
      CODE_ESC:  code_sel = ESC_BYTE;
      CODE_PEND: code_sel = pend_q;
      default:   code_sel = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      kind_o      <= cmd_i.out_kind;
      code_byte_o <= code_sel;
      last_o      <= cmd_i.out_last;
      if (cmd_i.out_kind == KIND_CSI) begin
        function_word_o <= func_q;
        param_total_o   <= 4'(cnt_q);
        param_index_o   <= 3'(idx_q);
        param_value_o   <= (cnt_q == '0) ? 16'd0 : ram_rdata;
      end else begin
        function_word_o <= '0;
        param_total_o   <= '0;
        param_index_o   <= '0;
        param_value_o   <= '0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/esp_ctrl.sv
// ----------------------------------------------------------------------------
// esp_ctrl
// Parser mode and sequencing of accepted bytes, CSI parameter runs and the
// result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module esp_ctrl import esp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire esp_sts_t sts_i,
  output esp_cmd_t      cmd_o
);

  localparam logic [1:0] ST_ACCEPT = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_LOAD   = 2'd2;
  localparam logic [1:0] ST_PEND   = 2'd3;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_CHAR = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;
  localparam logic [1:0] MODE_CSI  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [1:0] mode_q, mode_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       do_idle;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    cmd_o      = '0;
    do_idle    = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_ACCEPT: begin
        in_ready_o = out_free;
        if (in_valid_i && out_free) begin
          if (sts_i.chunk) begin
            if (mode_q == MODE_CHAR) begin
              mode_d = MODE_IDLE;
            end
          end else begin
            case (mode_q)
              MODE_CHAR: begin
                if (sts_i.is_c0) begin
                  do_idle = 1'b1;
                end else begin
                  cmd_o.out_load = 1'b1;
                  cmd_o.out_kind = KIND_CHAR;
                  cmd_o.out_code = CODE_BYTE;
                  cmd_o.out_last = 1'b1;
                end
              end
              MODE_ESC: begin
                if (sts_i.is_lbr) begin
                  cmd_o.csi_clear = 1'b1;
                  mode_d = MODE_CSI;
                end else if (sts_i.is_fe || sts_i.is_icf) begin
                  cmd_o.out_load = 1'b1;
                  cmd_o.out_kind = sts_i.is_fe ? KIND_C1 : KIND_ICF;
                  cmd_o.out_code = CODE_BYTE;
                  cmd_o.out_last = 1'b1;
                  mode_d = MODE_IDLE;
                end else begin
                  // The ESC turns into text: ESC first, this byte next.
                  cmd_o.out_load  = 1'b1;
                  cmd_o.out_kind  = KIND_CHAR;
                  cmd_o.out_code  = CODE_ESC;
                  cmd_o.pend_save = 1'b1;
                  mode_d  = MODE_CHAR;
                  state_d = ST_PEND;
                end
              end
              MODE_CSI: begin
                if (sts_i.is_par) begin
                  cmd_o.par_byte = 1'b1;
                end else if (sts_i.is_int) begin
                  cmd_o.inter = 1'b1;
                end else if (sts_i.is_fin) begin
                  cmd_o.fin = 1'b1;
                  mode_d  = MODE_IDLE;
                  state_d = ST_READ;
                end else begin
                  do_idle = 1'b1;
                end
              end
              default: begin
                do_idle = 1'b1;
              end
            endcase
          end
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_CSI;
          cmd_o.out_code = CODE_NONE;
          cmd_o.out_last = sts_i.run_last;
          if (sts_i.run_last) begin
            state_d = ST_ACCEPT;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d = ST_READ;
          end
        end
      end
      ST_PEND: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_CHAR;
          cmd_o.out_code = CODE_PEND;
          cmd_o.out_last = 1'b1;
          state_d = ST_ACCEPT;
        end
      end
      default: begin
        state_d = ST_ACCEPT;
      end
    endcase

    if (do_idle) begin
      if (sts_i.is_esc) begin
        mode_d = MODE_ESC;
      end else if (sts_i.is_csi8) begin
        cmd_o.csi_clear = 1'b1;
        mode_d = MODE_CSI;
      end else begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_last = 1'b1;
        if (sts_i.is_c0) begin
          cmd_o.out_kind = KIND_C0;
          cmd_o.out_code = CODE_BYTE;
          mode_d = MODE_IDLE;
        end else if (sts_i.is_c1) begin
          cmd_o.out_kind = KIND_C1;
          cmd_o.out_code = CODE_C1;
          mode_d = MODE_IDLE;
        end else begin
          cmd_o.out_kind = KIND_CHAR;
          cmd_o.out_code = CODE_BYTE;
          mode_d = MODE_CHAR;
        end
      end
    end

    out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCEPT;
      mode_q      <= MODE_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ecma48_escape_sequence_parser.sv
// ----------------------------------------------------------------------------
// ecma48_escape_sequence_parser
// Sorts a terminal byte stream into characters, C0 and C1 controls,
// independent control functions and CSI sequences with their parameters.
// ----------------------------------------------------------------------------
// A byte is taken every cycle while the result register is empty or being
// read, so plain characters, controls and sequence bytes flow at one item per
// cycle. An ESC that turns into text saves the byte after it and sends it next.
// A CSI final byte starts a run that reads the parameter store through its
// registered port in a read and a load state per result, a CSI without
// parameters counting as one result. No byte is taken while either runs.
`default_nettype none

module ecma48_escape_sequence_parser import esp_pkg::*; #(
  parameter int MAX_PARAMS = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  esp_in_if.sink      in_i,
  esp_out_if.source   out_o
);

  esp_sts_t sts;
  esp_cmd_t cmd;

  esp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  esp_datapath #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .data_byte_i     (in_i.data_byte),
    .chunk_end_i     (in_i.chunk_end),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .kind_o          (out_o.kind),
    .code_byte_o     (out_o.code_byte),
    .function_word_o (out_o.function_word),
    .param_total_o   (out_o.param_total),
    .param_index_o   (out_o.param_index),
    .param_value_o   (out_o.param_value),
    .last_o          (out_o.last)
  );

  a_accept_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |-> !out_o.valid || out_o.ready)
    else $error("Byte taken while the result register is blocked.");

  a_load_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !out_o.valid || out_o.ready)
    else $error("Result register overwritten before it was taken.");

  a_run_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.last |-> !in_i.ready)
    else $error("Byte taken in the middle of a result run.");

  a_non_csi_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.kind != KIND_CSI |->
      out_o.function_word == '0 && out_o.param_total == '0)
    else $error("CSI fields set on a non-CSI result.");

endmodule

`default_nettype wire
